// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever cond holds at a clock edge, prop must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed: implication");

// Whenever cond holds at a clock edge, prop must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/detc_pkg.sv =====
// Shared types and constants of the decay event timing classifier.
package detc_pkg;

  localparam int CHAN_W   = 9;
  localparam int ENERGY_W = 20;
  localparam int STAMP_W  = 48;
  localparam int STRIP_W  = 6;
  localparam int OSTRIP_W = 7;
  localparam int GAMMA_W  = 24;
  localparam int TIME_W   = 17;
  localparam int HALF_W   = 16;
  localparam int DIFF_W   = 19;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam int STRIPS_PER_SIDE_DEF = 40;
  localparam int BACK_BASE           = 80;
  localparam int GE_FIRST            = 208;
  localparam int GE_LAST             = 271;

  localparam logic [GAMMA_W-1:0]  GAMMA_MAX  = '1;
  localparam logic [OSTRIP_W-1:0] STRIP_NONE = '1;

  // Register indices of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROMPT_LOW   = 3'd0,
    REG_PROMPT_HIGH  = 3'd1,
    REG_DELAY_EARLY  = 3'd2,
    REG_DELAY_LATE   = 3'd3,
    REG_DELAY_HALF   = 3'd4,
    REG_GAMMA_LOW    = 3'd5,
    REG_GAMMA_HIGH   = 3'd6
  } cfg_reg_t;

  localparam logic signed [TIME_W-1:0] PROMPT_LOW_RST  = 17'sd40;
  localparam logic signed [TIME_W-1:0] PROMPT_HIGH_RST = 17'sd140;
  localparam logic signed [TIME_W-1:0] DELAY_EARLY_RST = -17'sd225;
  localparam logic signed [TIME_W-1:0] DELAY_LATE_RST  = 17'sd325;
  localparam logic [HALF_W-1:0]        DELAY_HALF_RST  = 16'd25;
  localparam logic [ENERGY_W-1:0]      GAMMA_LOW_RST   = 20'd160;
  localparam logic [ENERGY_W-1:0]      GAMMA_HIGH_RST  = 20'd64000;

  // Finished event state handed from the accumulator to the classifier.
  typedef struct packed {
    logic                 front_seen;
    logic [STRIP_W-1:0]   front_strip;
    logic [STAMP_W-1:0]   front_time;
    logic                 back_seen;
    logic [STRIP_W-1:0]   back_strip;
    logic [STAMP_W-1:0]   back_time;
    logic [GAMMA_W-1:0]   gamma;
  } snap_t;

endpackage

// ===== design/decay_event_timing_classifier_top.sv =====
// Top level of the decay event timing classifier.
// Hits enter on in_, one per cycle when not stalled, with in_tlast on the final
// hit of an event. For each event the block keeps the highest-energy front
// strip (channels 0 to STRIPS_PER_SIDE-1) and back strip (80 onward), counting
// only non-zero energies and keeping the earlier hit on a tie, and sums the
// germanium energies (channels 208 to 271) that lie strictly inside the gamma
// window, saturating at 24 bits. After the last hit one result item leaves on
// the out_ channel: strip indices (-1 when a side is empty), event time,
// prompt and delay flags from the front-minus-back time difference, and the
// gamma sum. The block takes one hit every cycle unless a result is stalled at
// the output; a result is presented after its last hit passes the input,
// accumulate and time difference registers. The pipeline has four registered
// stages (input, accumulate, time difference, classify) and a single stall
// enable: while a result waits on out_tready, the whole pipeline holds.
// Write the configuration registers only while no event is in flight.
`include "assert_macros.svh"

module decay_event_timing_classifier_top #(
  parameter int STRIPS_PER_SIDE = detc_pkg::STRIPS_PER_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // channel[8:0], energy[28:9], stamp[76:29], zero fill above
  input  logic [detc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  input  logic                             in_tlast,
  output logic                             in_tready,
  // front_strip[6:0], back_strip[13:7], event_time[61:14], time_valid[62],
  // is_prompt[63], is_delay[64], gamma_sum[88:65], zero fill above
  output logic [detc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [detc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [detc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DW = detc_pkg::DIFF_W;

  // configuration registers
  logic signed [detc_pkg::TIME_W-1:0] prompt_low_r, prompt_high_r;
  logic signed [detc_pkg::TIME_W-1:0] early_c_r, late_c_r;
  logic [detc_pkg::HALF_W-1:0]        half_r;
  logic [detc_pkg::ENERGY_W-1:0]      gamma_low_r, gamma_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prompt_low_r  <= detc_pkg::PROMPT_LOW_RST;
      prompt_high_r <= detc_pkg::PROMPT_HIGH_RST;
      early_c_r     <= detc_pkg::DELAY_EARLY_RST;
      late_c_r      <= detc_pkg::DELAY_LATE_RST;
      half_r        <= detc_pkg::DELAY_HALF_RST;
      gamma_low_r   <= detc_pkg::GAMMA_LOW_RST;
      gamma_high_r  <= detc_pkg::GAMMA_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        detc_pkg::REG_PROMPT_LOW:  prompt_low_r  <= cfg_wdata[detc_pkg::TIME_W-1:0];
        detc_pkg::REG_PROMPT_HIGH: prompt_high_r <= cfg_wdata[detc_pkg::TIME_W-1:0];
        detc_pkg::REG_DELAY_EARLY: early_c_r     <= cfg_wdata[detc_pkg::TIME_W-1:0];
        detc_pkg::REG_DELAY_LATE:  late_c_r      <= cfg_wdata[detc_pkg::TIME_W-1:0];
        detc_pkg::REG_DELAY_HALF:  half_r        <= cfg_wdata[detc_pkg::HALF_W-1:0];
        detc_pkg::REG_GAMMA_LOW:   gamma_low_r   <= cfg_wdata;
        detc_pkg::REG_GAMMA_HIGH:  gamma_high_r  <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // one enable for every stage: advance unless a result is stuck at the output
  logic step;
  logic out_valid_r;
  assign step      = !out_valid_r || out_tready;
  assign in_tready = step;

  // stage 1: input register
  logic                          v1_r;
  logic [detc_pkg::CHAN_W-1:0]   chan_r;
  logic [detc_pkg::ENERGY_W-1:0] energy_r;
  logic [detc_pkg::STAMP_W-1:0]  stamp_r;
  logic                          last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (step) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      chan_r   <= in_tdata[8:0];
      energy_r <= in_tdata[28:9];
      stamp_r  <= in_tdata[76:29];
      last_r   <= in_tlast;
    end
  end

  // stage 2: event accumulation
  logic            snap_valid;
  detc_pkg::snap_t snap;

  detc_accum #(
    .STRIPS_PER_SIDE(STRIPS_PER_SIDE)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .hit_valid (v1_r),
    .hit_chan  (chan_r),
    .hit_energy(energy_r),
    .hit_stamp (stamp_r),
    .hit_last  (last_r),
    .gamma_low (gamma_low_r),
    .gamma_high(gamma_high_r),
    .snap_valid(snap_valid),
    .snap      (snap)
  );

  // stage 3: front minus back, clamped to a width that keeps every window
  // compare exact (all bounds lie well inside the clamped range)
  logic signed [detc_pkg::STAMP_W:0] diff_full;
  logic signed [DW-1:0]              diff_clamp;
  logic                              fits;

  assign diff_full = $signed({1'b0, snap.front_time}) - $signed({1'b0, snap.back_time});
  assign fits = (diff_full[detc_pkg::STAMP_W:DW-1] == '0) ||
                (diff_full[detc_pkg::STAMP_W:DW-1] == '1);

  always_comb begin
    if (fits) begin
      diff_clamp = diff_full[DW-1:0];
    end else if (diff_full[detc_pkg::STAMP_W]) begin
      diff_clamp = {1'b1, {(DW-1){1'b0}}};
    end else begin
      diff_clamp = {1'b0, {(DW-1){1'b1}}};
    end
  end

  logic                                v3_r;
  logic                                both3_r;
  logic signed [DW-1:0]                diff3_r;
  logic [detc_pkg::OSTRIP_W-1:0]       fstrip3_r, bstrip3_r;
  logic [detc_pkg::STAMP_W-1:0]        time3_r;
  logic                                tvalid3_r;
  logic [detc_pkg::GAMMA_W-1:0]        gamma3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (step) begin
      v3_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      both3_r   <= snap.front_seen && snap.back_seen;
      diff3_r   <= diff_clamp;
      fstrip3_r <= snap.front_seen ? {1'b0, snap.front_strip} : detc_pkg::STRIP_NONE;
      bstrip3_r <= snap.back_seen ? {1'b0, snap.back_strip} : detc_pkg::STRIP_NONE;
      time3_r   <= snap.front_seen ? snap.front_time :
                   snap.back_seen  ? snap.back_time  : '0;
      tvalid3_r <= snap.front_seen || snap.back_seen;
      gamma3_r  <= snap.gamma;
    end
  end

  // stage 4: window compares into the output register
  logic signed [DW:0] d_x, pl_x, ph_x, e_lo, e_hi, l_lo, l_hi;
  logic               prompt_hit, delay_hit;

  assign d_x  = (DW+1)'(diff3_r);
  assign pl_x = (DW+1)'(prompt_low_r);
  assign ph_x = (DW+1)'(prompt_high_r);
  assign e_lo = (DW+1)'(early_c_r) - $signed({4'b0, half_r});
  assign e_hi = (DW+1)'(early_c_r) + $signed({4'b0, half_r});
  assign l_lo = (DW+1)'(late_c_r) - $signed({4'b0, half_r});
  assign l_hi = (DW+1)'(late_c_r) + $signed({4'b0, half_r});

  assign prompt_hit = both3_r && d_x >= pl_x && d_x <= ph_x;
  assign delay_hit  = both3_r && ((d_x >= e_lo && d_x <= e_hi) ||
                                  (d_x >= l_lo && d_x <= l_hi));

  logic [detc_pkg::OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {7'b0, gamma3_r, delay_hit, prompt_hit, tvalid3_r, time3_r,
                     bstrip3_r, fstrip3_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a timing flag needs both sides present
  `ASSERT_IMPLIES(a_flags_need_both, clk, rst_n,
    out_tvalid && (out_tdata[63] || out_tdata[64]),
    out_tdata[6:0] != detc_pkg::STRIP_NONE && out_tdata[13:7] != detc_pkg::STRIP_NONE)
  // time_valid matches presence of any strip
  `ASSERT_IMPLIES(a_time_valid, clk, rst_n, out_tvalid,
    out_tdata[62] == (out_tdata[6:0] != detc_pkg::STRIP_NONE ||
                      out_tdata[13:7] != detc_pkg::STRIP_NONE))
  // an empty event carries a zero time
  `ASSERT_IMPLIES(a_empty_time, clk, rst_n, out_tvalid && !out_tdata[62],
    out_tdata[61:14] == '0)
  // a stalled output freezes the pipeline, so no hit may be taken
  `ASSERT_IMPLIES(a_stall_blocks, clk, rst_n, out_tvalid && !out_tready, !in_tready)

endmodule

// ===== design/detc_accum.sv =====
// Per-event accumulator: best strip per side and gated gamma sum.
module detc_accum #(
  parameter int STRIPS_PER_SIDE = detc_pkg::STRIPS_PER_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          hit_valid,
  input  logic [detc_pkg::CHAN_W-1:0]   hit_chan,
  input  logic [detc_pkg::ENERGY_W-1:0] hit_energy,
  input  logic [detc_pkg::STAMP_W-1:0]  hit_stamp,
  input  logic                          hit_last,
  input  logic [detc_pkg::ENERGY_W-1:0] gamma_low,
  input  logic [detc_pkg::ENERGY_W-1:0] gamma_high,
  output logic                          snap_valid,
  output detc_pkg::snap_t               snap
);

  localparam logic [detc_pkg::CHAN_W-1:0] FRONT_END =
    detc_pkg::CHAN_W'(STRIPS_PER_SIDE);
  localparam logic [detc_pkg::CHAN_W-1:0] BACK_LO =
    detc_pkg::CHAN_W'(detc_pkg::BACK_BASE);
  localparam logic [detc_pkg::CHAN_W-1:0] BACK_END =
    detc_pkg::CHAN_W'(detc_pkg::BACK_BASE + STRIPS_PER_SIDE);
  localparam logic [detc_pkg::CHAN_W-1:0] GE_LO = detc_pkg::CHAN_W'(detc_pkg::GE_FIRST);
  localparam logic [detc_pkg::CHAN_W-1:0] GE_HI = detc_pkg::CHAN_W'(detc_pkg::GE_LAST);

  logic [detc_pkg::ENERGY_W-1:0] front_en_r, front_en_nxt;
  logic [detc_pkg::ENERGY_W-1:0] back_en_r, back_en_nxt;
  detc_pkg::snap_t               st_r, st_nxt;
  logic                          snap_valid_r;
  detc_pkg::snap_t               snap_r;
  logic [detc_pkg::CHAN_W-1:0]   back_idx;
  logic [detc_pkg::GAMMA_W:0]    gsum;

  assign back_idx = hit_chan - BACK_LO;
  assign gsum = {1'b0, st_r.gamma} + (detc_pkg::GAMMA_W + 1)'(hit_energy);

  always_comb begin
    front_en_nxt = front_en_r;
    back_en_nxt  = back_en_r;
    st_nxt       = st_r;
    if (hit_chan < FRONT_END) begin
      if (hit_energy > front_en_r) begin
        front_en_nxt      = hit_energy;
        st_nxt.front_seen  = 1'b1;
        st_nxt.front_strip = hit_chan[detc_pkg::STRIP_W-1:0];
        st_nxt.front_time  = hit_stamp;
      end
    end else if (hit_chan >= BACK_LO && hit_chan < BACK_END) begin
      if (hit_energy > back_en_r) begin
        back_en_nxt       = hit_energy;
        st_nxt.back_seen  = 1'b1;
        st_nxt.back_strip = back_idx[detc_pkg::STRIP_W-1:0];
        st_nxt.back_time  = hit_stamp;
      end
    end else if (hit_chan >= GE_LO && hit_chan <= GE_HI) begin
      if (hit_energy > gamma_low && hit_energy < gamma_high) begin
        st_nxt.gamma = gsum[detc_pkg::GAMMA_W] ? detc_pkg::GAMMA_MAX
                                               : gsum[detc_pkg::GAMMA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_en_r   <= '0;
      back_en_r    <= '0;
      st_r         <= '0;
      snap_valid_r <= 1'b0;
    end else if (step) begin
      snap_valid_r <= hit_valid && hit_last;
      if (hit_valid) begin
        if (hit_last) begin
          // hand over the finished event and start afresh
          front_en_r <= '0;
          back_en_r  <= '0;
          st_r       <= '0;
        end else begin
          front_en_r <= front_en_nxt;
          back_en_r  <= back_en_nxt;
          st_r       <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      snap_r <= st_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule
